@@ sv/assert_macros.svh @@
// Assertion macros shared by the order book RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define OBPL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// condition in one cycle implies a consequence in the next
`define OBPL_ASSERT_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error(msg);

`endif

@@ sv/obpl_pkg.sv @@
// Types and constants of the order book price level unit.
`default_nettype none
package obpl_pkg;

    localparam int MAX_LEVELS       = 64;
    localparam int ORDERS_PER_LEVEL = 16;
    localparam int PRICE_BITS       = 32;
    localparam int ORDER_ID_BITS    = 32;

    localparam int LVL_IW = $clog2(MAX_LEVELS);
    localparam int CNT_W  = $clog2(MAX_LEVELS + 1);
    localparam int FILL_W = $clog2(ORDERS_PER_LEVEL + 1);

    typedef struct packed {
        logic [PRICE_BITS-1:0]    price;
        logic [FILL_W-1:0]        fill;
        logic [ORDER_ID_BITS-1:0] first;
    } t_level;

    localparam int LEVEL_W = $bits(t_level);

    typedef enum logic [1:0] {
        OP_PUSH_BID = 2'd0,
        OP_PUSH_ASK = 2'd1,
        OP_POP_BID  = 2'd2,
        OP_POP_ASK  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TABLE_FULL = 2'd1,
        ST_FIFO_FULL  = 2'd2,
        ST_EMPTY      = 2'd3
    } t_status;

endpackage
`default_nettype wire

@@ sv/obpl_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none
module obpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

@@ sv/order_book_price_levels_unit.sv @@
// Top level of the order book price level unit: sequencer and level tables.
//
// Input channel: i_valid/o_stall carries one operation per transaction
// (push bid, push ask, pop best bid level, pop best ask level) with price
// and order identifier. Output channel: o_valid/i_stall carries one result
// per operation: status plus the best level of each side.
// Each side keeps its levels sorted best first in a RAM of one entry per
// level (price, fill count, oldest order). One RAM read and one write port
// per side serve all steps, one level per cycle.
// Steps: a push scans from the best level down until it meets a level that
// is not better; on an equal price it adds the order there, else an
// insertion moves the worse levels down one place. A pop moves the remaining
// levels up one place. Place (insertion only), read-back and output follow.
// o_stall is high whenever the sequencer is not idle, from acceptance until
// the result is taken, so a new operation waits for the last result.
// Reset empties both sides at once; RAM contents need no clearing.
// While i_stall is high the result is held unchanged on the outputs.
`default_nettype none
`include "assert_macros.svh"
module order_book_price_levels_unit
    import obpl_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [1:0]               i_operation,
    input  wire logic [PRICE_BITS-1:0]    i_price,
    input  wire logic [ORDER_ID_BITS-1:0] i_order_id,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [1:0]                    o_status,
    output logic                          o_bid_empty,
    output logic [PRICE_BITS-1:0]         o_best_bid_price,
    output logic [ORDER_ID_BITS-1:0]      o_best_bid_first_order,
    output logic [FILL_W-1:0]             o_best_bid_order_count,
    output logic                          o_ask_empty,
    output logic [PRICE_BITS-1:0]         o_best_ask_price,
    output logic [ORDER_ID_BITS-1:0]      o_best_ask_first_order,
    output logic [FILL_W-1:0]             o_best_ask_order_count
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SCAN  = 8'b0000_0010,
        S_INS   = 8'b0000_0100,
        S_PLACE = 8'b0000_1000,
        S_DEL   = 8'b0001_0000,
        S_RPT   = 8'b0010_0000,
        S_LATCH = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state                   r_state, n_state;
    logic                     r_side, n_side;
    logic [PRICE_BITS-1:0]    r_price, n_price;
    logic [ORDER_ID_BITS-1:0] r_id, n_id;
    logic [CNT_W-1:0]         r_cnt_bid, n_cnt_bid;
    logic [CNT_W-1:0]         r_cnt_ask, n_cnt_ask;
    logic [CNT_W-1:0]         r_idx, n_idx;
    logic [CNT_W-1:0]         r_pos, n_pos;
    logic [LVL_IW-1:0]        r_wa, n_wa;
    logic                     r_dv, n_dv;
    t_status                  r_status, n_status;
    logic                     r_ovalid, n_ovalid;

    logic [1:0]               r_o_status;
    logic                     r_o_bid_empty, r_o_ask_empty;
    logic [PRICE_BITS-1:0]    r_o_bid_price, r_o_ask_price;
    logic [ORDER_ID_BITS-1:0] r_o_bid_first, r_o_ask_first;
    logic [FILL_W-1:0]        r_o_bid_count, r_o_ask_count;

    logic [LVL_IW-1:0] w_rd_addr, w_wr_addr;
    logic              w_wr_en;
    t_level            w_wr_data;
    t_level            w_rd_bid, w_rd_ask, w_rd;
    logic [CNT_W-1:0]  w_cnt, w_op_cnt, w_idx_p1, w_idx_m1, w_ins_pos;
    logic              w_better, w_equal, w_go_ins;

    obpl_ram #(.WIDTH(LEVEL_W), .DEPTH(MAX_LEVELS)) u_bid_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en & ~r_side),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_bid)
    );

    obpl_ram #(.WIDTH(LEVEL_W), .DEPTH(MAX_LEVELS)) u_ask_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en & r_side),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_ask)
    );

    assign w_rd     = r_side ? w_rd_ask : w_rd_bid;
    assign w_cnt    = r_side ? r_cnt_ask : r_cnt_bid;
    assign w_op_cnt = i_operation[0] ? r_cnt_ask : r_cnt_bid;
    assign w_idx_p1 = CNT_W'(r_idx + 1'b1);
    assign w_idx_m1 = CNT_W'(r_idx - 1'b1);
    assign w_better = r_side ? (w_rd.price < r_price) : (w_rd.price > r_price);
    assign w_equal  = (w_rd.price == r_price);

    always_comb begin
        n_state   = r_state;
        n_side    = r_side;
        n_price   = r_price;
        n_id      = r_id;
        n_cnt_bid = r_cnt_bid;
        n_cnt_ask = r_cnt_ask;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_wa      = r_wa;
        n_dv      = r_dv;
        n_status  = r_status;
        n_ovalid  = r_ovalid;
        w_rd_addr = '0;
        w_wr_addr = r_wa;
        w_wr_en   = 1'b0;
        w_wr_data = w_rd;
        w_go_ins  = 1'b0;
        w_ins_pos = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_side   = i_operation[0];
                    n_price  = i_price;
                    n_id     = i_order_id;
                    n_status = ST_OK;
                    n_idx    = '0;
                    n_dv     = 1'b0;
                    if (t_op'(i_operation) == OP_PUSH_BID
                            || t_op'(i_operation) == OP_PUSH_ASK) begin
                        n_state = S_SCAN;
                    end else if (w_op_cnt == '0) begin
                        n_status = ST_EMPTY;
                        n_state  = S_RPT;
                    end else begin
                        n_idx   = CNT_W'(1);
                        n_state = S_DEL;
                    end
                end
            end
            S_SCAN: begin
                if (r_dv && !w_better) begin
                    if (w_equal) begin
                        if (w_rd.fill >= FILL_W'(ORDERS_PER_LEVEL)) begin
                            n_status = ST_FIFO_FULL;
                        end else begin
                            w_wr_en        = 1'b1;
                            w_wr_addr      = w_idx_m1[LVL_IW-1:0];
                            w_wr_data.fill = FILL_W'(w_rd.fill + 1'b1);
                        end
                        n_state = S_RPT;
                    end else begin
                        w_go_ins  = 1'b1;
                        w_ins_pos = w_idx_m1;
                    end
                end else if (r_idx < w_cnt) begin
                    w_rd_addr = r_idx[LVL_IW-1:0];
                    n_idx     = w_idx_p1;
                    n_dv      = 1'b1;
                end else begin
                    w_go_ins  = 1'b1;
                    w_ins_pos = r_idx;
                end
                if (w_go_ins) begin
                    n_dv = 1'b0;
                    if (w_cnt >= CNT_W'(MAX_LEVELS)) begin
                        n_status = ST_TABLE_FULL;
                        n_state  = S_RPT;
                    end else begin
                        n_pos   = w_ins_pos;
                        n_idx   = w_cnt;
                        n_state = S_INS;
                    end
                end
            end
            S_INS: begin
                w_wr_en = r_dv;
                if (r_idx > r_pos) begin
                    w_rd_addr = w_idx_m1[LVL_IW-1:0];
                    n_wa      = r_idx[LVL_IW-1:0];
                    n_idx     = w_idx_m1;
                    n_dv      = 1'b1;
                end else begin
                    n_dv = 1'b0;
                    if (!r_dv) begin
                        n_state = S_PLACE;
                    end
                end
            end
            S_PLACE: begin
                w_wr_en         = 1'b1;
                w_wr_addr       = r_pos[LVL_IW-1:0];
                w_wr_data.price = r_price;
                w_wr_data.fill  = FILL_W'(1);
                w_wr_data.first = r_id;
                if (r_side) begin
                    n_cnt_ask = CNT_W'(r_cnt_ask + 1'b1);
                end else begin
                    n_cnt_bid = CNT_W'(r_cnt_bid + 1'b1);
                end
                n_state = S_RPT;
            end
            S_DEL: begin
                w_wr_en = r_dv;
                if (r_idx < w_cnt) begin
                    w_rd_addr = r_idx[LVL_IW-1:0];
                    n_wa      = w_idx_m1[LVL_IW-1:0];
                    n_idx     = w_idx_p1;
                    n_dv      = 1'b1;
                end else begin
                    n_dv = 1'b0;
                    if (!r_dv) begin
                        if (r_side) begin
                            n_cnt_ask = CNT_W'(r_cnt_ask - 1'b1);
                        end else begin
                            n_cnt_bid = CNT_W'(r_cnt_bid - 1'b1);
                        end
                        n_state = S_RPT;
                    end
                end
            end
            S_RPT: begin
                n_state = S_LATCH;
            end
            S_LATCH: begin
                n_ovalid = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_ovalid = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt_bid <= '0;
            r_cnt_ask <= '0;
            r_dv      <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt_bid <= n_cnt_bid;
            r_cnt_ask <= n_cnt_ask;
            r_dv      <= n_dv;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side   <= n_side;
        r_price  <= n_price;
        r_id     <= n_id;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_wa     <= n_wa;
        r_status <= n_status;
        if (r_state == S_LATCH) begin
            r_o_status    <= r_status;
            r_o_bid_empty <= (r_cnt_bid == '0);
            r_o_ask_empty <= (r_cnt_ask == '0);
            r_o_bid_price <= (r_cnt_bid == '0) ? '0 : w_rd_bid.price;
            r_o_bid_first <= (r_cnt_bid == '0) ? '0 : w_rd_bid.first;
            r_o_bid_count <= (r_cnt_bid == '0) ? '0 : w_rd_bid.fill;
            r_o_ask_price <= (r_cnt_ask == '0) ? '0 : w_rd_ask.price;
            r_o_ask_first <= (r_cnt_ask == '0) ? '0 : w_rd_ask.first;
            r_o_ask_count <= (r_cnt_ask == '0) ? '0 : w_rd_ask.fill;
        end
    end

    assign o_stall                = (r_state != S_IDLE);
    assign o_valid                = r_ovalid;
    assign o_status               = r_o_status;
    assign o_bid_empty            = r_o_bid_empty;
    assign o_best_bid_price       = r_o_bid_price;
    assign o_best_bid_first_order = r_o_bid_first;
    assign o_best_bid_order_count = r_o_bid_count;
    assign o_ask_empty            = r_o_ask_empty;
    assign o_best_ask_price       = r_o_ask_price;
    assign o_best_ask_first_order = r_o_ask_first;
    assign o_best_ask_order_count = r_o_ask_count;

    `OBPL_ASSERT(a_cnt_range, (r_cnt_bid <= CNT_W'(MAX_LEVELS)) && (r_cnt_ask <= CNT_W'(MAX_LEVELS)), "level count beyond table size")
    `OBPL_ASSERT(a_valid_state, r_ovalid == (r_state == S_OUT), "result valid outside output state")
    `OBPL_ASSERT(a_empty_zero, !(r_ovalid && o_bid_empty) || (o_best_bid_order_count == '0), "empty bid side reports orders")
    `OBPL_ASSERT_NEXT(a_place_inc, (r_state == S_PLACE) && !r_side, r_cnt_bid == CNT_W'($past(r_cnt_bid) + 1'b1), "bid insertion did not add a level")
    `OBPL_ASSERT(a_cnt_change, !$past(i_rst_n) || (r_cnt_ask == $past(r_cnt_ask)) || ($past(r_state) == S_PLACE) || ($past(r_state) == S_DEL), "ask level count changed outside insert or delete")

endmodule
`default_nettype wire
